[hdl/rne_pkg.sv]
// Shared types, symbol tables and helpers for the roman numeral encoder
`timescale 1ns / 1ps

package rne_pkg;

  // greedy symbol table size and widths
  localparam int SymCount     = 13;
  localparam int NumberWidth  = 12;
  localparam int CharWidth    = 7;
  localparam int SymIdxWidth  = 4;
  localparam int QueueDepthDefault = 4;

  typedef logic [NumberWidth-1:0] number_t;
  typedef logic [CharWidth-1:0]   ascii_t;
  typedef logic [SymIdxWidth-1:0] sym_idx_t;

  // letter codes
  localparam ascii_t ChC = 7'h43;
  localparam ascii_t ChD = 7'h44;
  localparam ascii_t ChI = 7'h49;
  localparam ascii_t ChL = 7'h4C;
  localparam ascii_t ChM = 7'h4D;
  localparam ascii_t ChV = 7'h56;
  localparam ascii_t ChX = 7'h58;
  localparam ascii_t ChNone = 7'h00;

  // one symbol request passed from the front to the back
  typedef struct packed {
    sym_idx_t idx;
    logic     last;
  } sym_req_t;

  // symbol value, largest first
  function automatic number_t sym_value(input sym_idx_t idx);
    number_t v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      4'd12:   v = 12'd1;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  // first letter of each symbol
  function automatic ascii_t sym_first(input sym_idx_t idx);
    ascii_t c;
    case (idx)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      4'd11:   c = ChI;
      4'd12:   c = ChI;
      default: c = ChI;
    endcase
    return c;
  endfunction

  // second letter of each symbol, none for single-letter symbols
  function automatic ascii_t sym_second(input sym_idx_t idx);
    ascii_t c;
    case (idx)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChNone;
    endcase
    return c;
  endfunction

endpackage

[hdl/roman_numeral_encoder.sv]
// Top level of the roman numeral encoder
//
// Input channel: in_valid / in_stall with number_value, a 12-bit unsigned
// number. Output channel: out_valid / out_stall with numeral_char (ASCII of
// one of C D I L M V X) and last_char, set on the final letter of a numeral.
// A request moves when valid is high and stall is low.
// Each number yields its Roman numeral by the greedy rule, one letter per
// request; zero yields nothing; 4000 and up give extra leading M letters.
// A taken number's first letter goes through the queue and the output register.
// The front picks one symbol per cycle while the queue is not full and pushes
// it into a short queue; the back emits one letter per cycle from an output
// register while the receiver does not stall, holding the second letter of a
// two-letter symbol in a pending register. A numeral has at most 15 letters;
// the front takes the next number as soon as it has queued the last symbol
// of the current one.
// When the receiver stalls, the output holds, the queue fills and the front
// then stops; in_stall is high whenever the front is busy with a number.
// Synchronous reset empties the queue and drops all pending letters.
`timescale 1ns / 1ps

module roman_numeral_encoder
  import rne_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  number_t number_value,
  output logic    out_valid,
  input  logic    out_stall,
  output ascii_t  numeral_char,
  output logic    last_char
);

  logic     push_valid;
  sym_req_t push_data;
  logic     push_full;
  logic     pop;
  sym_req_t pop_data;
  logic     empty;

  // symbol selection
  rne_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .number_value (number_value),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_full    (push_full)
  );

  // decoupling queue
  rne_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (push_full),
    .pop        (pop),
    .pop_data   (pop_data),
    .empty      (empty)
  );

  // letter output
  rne_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop          (pop),
    .pop_data     (pop_data),
    .empty        (empty),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .numeral_char (numeral_char),
    .last_char    (last_char)
  );

endmodule

[hdl/rne_front.sv]
// Front end: accepts a number and splits it into greedy symbol requests
`timescale 1ns / 1ps

module rne_front
  import rne_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  number_t  number_value,
  output logic     push_valid,
  output sym_req_t push_data,
  input  logic     push_full
);

  logic     busy;
  number_t  remaining_value;
  number_t  remaining_next;
  sym_idx_t sel;
  logic     accept;
  logic     step;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign step     = busy && !push_full;

  // pick the largest symbol not above the remaining value
  always_comb begin
    sel = SymIdxWidth'(SymCount - 1);
    for (int i = SymCount - 1; i >= 0; i--) begin
      if (remaining_value >= sym_value(SymIdxWidth'(i))) begin
        sel = SymIdxWidth'(i);
      end
    end
    remaining_next = remaining_value - sym_value(sel);
  end

  assign push_valid     = busy;
  assign push_data.idx  = sel;
  assign push_data.last = (remaining_next == '0);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= (number_value != '0);
    end else if (step && remaining_next == '0) begin
      busy <= 1'b0;
    end
  end

  // remaining value
  always_ff @(posedge clk) begin
    if (accept) begin
      remaining_value <= number_value;
    end else if (step) begin
      remaining_value <= remaining_next;
    end
  end

endmodule

[hdl/rne_queue.sv]
// Short queue of symbol requests between front and back
`timescale 1ns / 1ps

module rne_queue
  import rne_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  input  sym_req_t push_data,
  output logic     full,
  input  logic     pop,
  output sym_req_t pop_data,
  output logic     empty
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  sym_req_t              entries [Depth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CntWidth-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (count == CntWidth'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push_valid && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/rne_back.sv]
// Back end: turns symbol requests into letters, one per cycle unless the receiver stalls
`timescale 1ns / 1ps

module rne_back
  import rne_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  output logic     pop,
  input  sym_req_t pop_data,
  input  logic     empty,
  output logic     out_valid,
  input  logic     out_stall,
  output ascii_t   numeral_char,
  output logic     last_char
);

  logic   load;
  logic   pend;
  ascii_t pend_char;
  logic   pend_last;
  ascii_t second;
  logic   two;

  assign load   = !out_valid || !out_stall;
  assign pop    = load && !pend && !empty;
  assign second = sym_second(pop_data.idx);
  assign two    = (second != ChNone);

  // output register and pending second letter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        pend      <= two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // letter payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        numeral_char <= pend_char;
        last_char    <= pend_last;
      end else if (!empty) begin
        numeral_char <= sym_first(pop_data.idx);
        last_char    <= pop_data.last && !two;
        pend_char    <= second;
        pend_last    <= pop_data.last;
      end
    end
  end

endmodule

[verif/roman_numeral_encoder_test.sv]
// Self-checking testbench for the roman numeral encoder: directed and random numbers
`timescale 1ns / 1ps

module roman_numeral_encoder_test;
  import rne_pkg::*;

  localparam int DirCount    = 25;
  localparam int RandCount   = 185;
  localparam int ItemCount   = DirCount + RandCount;
  localparam int DrainCycles = 20;
  localparam int SymbolTotal = 13;
  // directed row whose letters come from the predictor
  localparam string Predicted = "*";

  typedef struct packed {
    ascii_t ch;
    logic   last;
  } letter_t;

  typedef struct packed {
    number_t weight;
    ascii_t  first;
    ascii_t  second;
  } symbol_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  number_t number_value = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  ascii_t  numeral_char;
  logic    last_char;

  letter_t pending_letters[$];
  int      mismatch_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  number_t dir_number [DirCount];
  string   dir_text [DirCount];

  roman_numeral_encoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .number_value (number_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .numeral_char (numeral_char),
    .last_char    (last_char)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // greedy symbols, largest first
  function automatic symbol_t greedy_symbol(input int pos);
    case (pos)
      0:       return symbol_t'{12'd1000, ChM, ChNone};
      1:       return symbol_t'{12'd900,  ChC, ChM};
      2:       return symbol_t'{12'd500,  ChD, ChNone};
      3:       return symbol_t'{12'd400,  ChC, ChD};
      4:       return symbol_t'{12'd100,  ChC, ChNone};
      5:       return symbol_t'{12'd90,   ChX, ChC};
      6:       return symbol_t'{12'd50,   ChL, ChNone};
      7:       return symbol_t'{12'd40,   ChX, ChL};
      8:       return symbol_t'{12'd10,   ChX, ChNone};
      9:       return symbol_t'{12'd9,    ChI, ChX};
      10:      return symbol_t'{12'd5,    ChV, ChNone};
      11:      return symbol_t'{12'd4,    ChI, ChV};
      default: return symbol_t'{12'd1,   ChI, ChNone};
    endcase
  endfunction

  // queue the letters of one number, last flag on the final one
  task automatic predict_numeral(input number_t value);
    int      rem;
    int      pos;
    symbol_t sym;
    rem = value;
    pos = 0;
    while (rem != 0 && pos < SymbolTotal) begin
      sym = greedy_symbol(pos);
      if (rem >= sym.weight) begin
        rem -= sym.weight;
        if (sym.second == ChNone) begin
          pending_letters.push_back(letter_t'{sym.first, rem == 0});
        end else begin
          pending_letters.push_back(letter_t'{sym.first, 1'b0});
          pending_letters.push_back(letter_t'{sym.second, rem == 0});
        end
      end else begin
        pos++;
      end
    end
  endtask

  // queue letters typed as a string
  task automatic expect_text(input string text);
    int n;
    n = text.len();
    for (int i = 0; i < n; i++) begin
      pending_letters.push_back(letter_t'{ascii_t'(text[i]), i == n - 1});
    end
  endtask

  // random number, weighted toward short, long and digit-built numerals
  function automatic number_t random_number();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      v = 0;
    end else if (pick < 20) begin
      v = $urandom_range(1, 20);
    end else if (pick < 35) begin
      v = $urandom_range(3000, 4095);
    end else if (pick < 55) begin
      // each decimal digit drawn alone so that 4, 8 and 9 appear often
      v = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
          $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
    end else begin
      v = $urandom_range(0, 4095);
    end
    return number_t'(v);
  endfunction

  // one request on the input side, expectations queued on acceptance
  task automatic send_number(input number_t value, input string text);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    number_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (text == Predicted) begin
      predict_numeral(value);
    end else begin
      expect_text(text);
    end
    @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // compare each accepted letter with the oldest expectation
  always @(posedge clk) begin : check_letters
    letter_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_letters.size() == 0) begin
        $error("unexpected letter: numeral_char %0d last_char %0b", numeral_char, last_char);
        mismatch_count++;
      end else begin
        want = pending_letters.pop_front();
        if (numeral_char !== want.ch) begin
          $error("numeral_char: expected %0d, actual %0d", want.ch, numeral_char);
          mismatch_count++;
        end
        if (last_char !== want.last) begin
          $error("last_char: expected %0b, actual %0b", want.last, last_char);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    dir_number = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50,
                   12'd90, 12'd100, 12'd400, 12'd500, 12'd900, 12'd1000,
                   12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd0, 12'd2048,
                   12'd1365, 12'd2730, 12'd14, 12'd49, 12'd3444};
    dir_text = '{"", "I", "IV", "V", "IX", "X", "XL", "L",
                 "XC", "C", "CD", "D", "CM", "M",
                 "MMMDCCCLXXXVIII", "MMMCMXCIX", "MMMM", "MMMMXCV", "", Predicted,
                 Predicted, Predicted, Predicted, Predicted, Predicted};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < ItemCount; k++) begin
      // three idle phases over the run
      case (k * 3 / ItemCount)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (k < DirCount) begin
        send_number(dir_number[k], dir_text[k]);
      end else begin
        send_number(random_number(), Predicted);
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray letters
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_letters.size() == 0) begin
      $display("roman_numeral_encoder regression: pass");
    end else begin
      $display("roman_numeral_encoder regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("roman_numeral_encoder regression: fail");
    $finish;
  end

endmodule
